[rtl/core/ermg_pkg.sv]
// Package for the Euler rotation matrix generator: types, constants, tables.
package ermg_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 14;

	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	localparam int NUM_REGS = 7;
	localparam int ADDR_W   = 5;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_BASE_X = 3'd1,
		REG_BASE_Y = 3'd2,
		REG_BASE_Z = 3'd3,
		REG_SPEED_X = 3'd4,
		REG_SPEED_Y = 3'd5,
		REG_SPEED_Z = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] delta_time;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] matrix_e0;
		logic signed [15:0] matrix_e1;
		logic signed [15:0] matrix_e2;
		logic signed [15:0] matrix_e3;
		logic signed [15:0] matrix_e4;
		logic signed [15:0] matrix_e5;
		logic signed [15:0] matrix_e6;
		logic signed [15:0] matrix_e7;
		logic signed [15:0] matrix_e8;
		logic [31:0]        elapsed_time;
	} out_word_t;

	// Taylor divisors: sine (2k)(2k+1), cosine (2k-1)(2k)
	function automatic logic [7:0] sin_div(input logic [2:0] k);
		logic [7:0] d;
		case (k)
			3'd1: d = 8'd6;
			3'd2: d = 8'd20;
			3'd3: d = 8'd42;
			3'd4: d = 8'd72;
			3'd5: d = 8'd110;
			3'd6: d = 8'd156;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] cos_div(input logic [2:0] k);
		logic [7:0] d;
		case (k)
			3'd1: d = 8'd2;
			3'd2: d = 8'd12;
			3'd3: d = 8'd30;
			3'd4: d = 8'd56;
			3'd5: d = 8'd90;
			3'd6: d = 8'd132;
			3'd7: d = 8'd182;
			default: d = 8'd1;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/ermg_if.sv]
// Valid/ready channel interfaces for input and result words.
interface ermg_in_if;
	import ermg_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ermg_out_if;
	import ermg_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/euler_rotation_matrix_generator_top.sv]
// Top level: config registers, angle/time state, sin/cos and matrix sequencer.
// Each result word is computed by the shared bit-serial multiplier and divider.
// Throughput: one word at a time; the next word is taken the cycle after the result
// leaves. Output stalls delay the next word.
// A word taken while disabled yields no result and changes no state.
// Reset clears config, accumulators, time and FSM control; no clearing pass.
module euler_rotation_matrix_generator_top #(
	parameter int ANGLE_BITS = ermg_pkg::ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = ermg_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ermg_in_if.sink                    in_ch,
	ermg_out_if.source                 out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ermg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ermg_pkg::*;

	localparam int SH = 30 - FRAC_BITS;
	localparam logic [34:0] RND = (SH > 0) ? (35'd1 << (SH - 1)) : 35'd0;
	localparam logic [34:0] LIM = 35'd1 << FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_ANG, S_THETA, S_TH2, S_SMUL, S_SDIV, S_CMUL, S_CDIV,
		S_AXEND, S_PSTART, S_PROD, S_OUT
	} state_t;

	state_t state_q;

	logic        enable_q;
	logic [15:0] base_q [3];
	logic [15:0] speed_q [3];
	logic [ANGLE_BITS-1:0] accum_q [3];
	logic [31:0] time_q;

	logic [1:0]  ax_q;
	logic [1:0]  quad_q;
	logic [31:0] theta_q;
	logic [31:0] th2_q;
	logic [2:0]  k_q;
	logic signed [34:0] ssum_q;
	logic signed [34:0] csum_q;
	logic signed [31:0] s_q [3];
	logic signed [31:0] c_q [3];
	logic signed [31:0] sxsy_q;
	logic signed [31:0] cxsy_q;
	logic signed [33:0] tmp_q;
	logic signed [33:0] ent_q [9];
	logic [3:0]  pidx_q;
	logic        neg_q;

	logic        mul_start_q;
	logic [31:0] mul_a_q;
	logic [31:0] mul_b_q;
	logic        mul_done;
	logic [63:0] mul_prod;
	logic        div_start_q;
	logic [31:0] div_n_q;
	logic [7:0]  div_d_q;
	logic        div_done;
	logic [31:0] div_quo;

	logic        out_valid_q;
	out_word_t   out_q;

	logic        wr;
	logic        acc;
	logic [47:0] base_w;
	logic [ANGLE_BITS-1:0] ang;
	logic [31:0] tfrac;
	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [33:0] mres;
	logic [32:0] tsum;
	logic signed [34:0] qv;
	logic [30:0] sv;
	logic [30:0] cv;

	ermg_smul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .prod(mul_prod)
	);

	ermg_sdiv u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(div_n_q),
		.divisor(div_d_q), .done(div_done), .quo(div_quo)
	);

	function automatic logic [30:0] clamp_unit(input logic signed [34:0] v);
		logic [30:0] r;
		if (v < 0) r = '0;
		else if (v > $signed({3'b0, ONE_Q30})) r = ONE_Q30[30:0];
		else r = v[30:0];
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [15:0] to_out(input logic signed [33:0] v);
		logic [34:0] m;
		if (v[33]) m = 35'(-$signed({v[33], v}));
		else m = {1'b0, v};
		m = (m + RND) >> SH;
		if (m > LIM) m = LIM;
		if (v[33]) m = 35'(-m);
		return m[15:0];
	endfunction

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign acc    = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_comb begin
		case (paddr[4:2])
			REG_ENABLE:  prdata = {31'd0, enable_q};
			REG_BASE_X:  prdata = {16'd0, base_q[0]};
			REG_BASE_Y:  prdata = {16'd0, base_q[1]};
			REG_BASE_Z:  prdata = {16'd0, base_q[2]};
			REG_SPEED_X: prdata = {16'd0, speed_q[0]};
			REG_SPEED_Y: prdata = {16'd0, speed_q[1]};
			REG_SPEED_Z: prdata = {16'd0, speed_q[2]};
			default:     prdata = '0;
		endcase
	end

	// effective angle of the current axis, as a 32-bit turn fraction
	assign base_w = {32'd0, base_q[ax_q]};
	assign ang    = ANGLE_BITS'(base_w[ANGLE_BITS-1:0] + accum_q[ax_q]);
	assign tfrac  = {ang, {(32 - ANGLE_BITS){1'b0}}};
	assign tsum   = {1'b0, time_q} + {17'd0, in_ch.data.delta_time};

	always_comb begin
		case (pidx_q)
			4'd0:  begin op_a = s_q[0];  op_b = s_q[1]; end
			4'd1:  begin op_a = c_q[0];  op_b = s_q[1]; end
			4'd2:  begin op_a = c_q[1];  op_b = c_q[2]; end
			4'd3:  begin op_a = c_q[1];  op_b = s_q[2]; end
			4'd4:  begin op_a = sxsy_q;  op_b = c_q[2]; end
			4'd5:  begin op_a = c_q[0];  op_b = s_q[2]; end
			4'd6:  begin op_a = sxsy_q;  op_b = s_q[2]; end
			4'd7:  begin op_a = c_q[0];  op_b = c_q[2]; end
			4'd8:  begin op_a = s_q[0];  op_b = c_q[1]; end
			4'd9:  begin op_a = cxsy_q;  op_b = c_q[2]; end
			4'd10: begin op_a = s_q[0];  op_b = s_q[2]; end
			4'd11: begin op_a = cxsy_q;  op_b = s_q[2]; end
			4'd12: begin op_a = s_q[0];  op_b = c_q[2]; end
			default: begin op_a = c_q[0]; op_b = c_q[1]; end
		endcase
	end

	assign mres = neg_q ? -$signed({2'b00, mul_prod[61:30]})
			: $signed({2'b00, mul_prod[61:30]});
	assign qv   = $signed({3'b000, div_quo});
	assign sv   = clamp_unit(ssum_q);
	assign cv   = clamp_unit(csum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				base_q[i]  <= '0;
				speed_q[i] <= '0;
				accum_q[i] <= '0;
			end
			time_q      <= '0;
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			ax_q        <= '0;
			k_q         <= '0;
			pidx_q      <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (wr) begin
				case (paddr[4:2])
					REG_ENABLE:  enable_q   <= pwdata[0];
					REG_BASE_X:  base_q[0]  <= pwdata[15:0];
					REG_BASE_Y:  base_q[1]  <= pwdata[15:0];
					REG_BASE_Z:  base_q[2]  <= pwdata[15:0];
					REG_SPEED_X: speed_q[0] <= pwdata[15:0];
					REG_SPEED_Y: speed_q[1] <= pwdata[15:0];
					REG_SPEED_Z: speed_q[2] <= pwdata[15:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (acc && enable_q) begin
						time_q <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
						for (int i = 0; i < 3; i++)
							accum_q[i] <= ANGLE_BITS'(accum_q[i] +
								{{(ANGLE_BITS + 32){speed_q[i][15]}}, speed_q[i]});
						ax_q    <= '0;
						state_q <= S_ANG;
					end
				end
				S_ANG: begin
					quad_q      <= tfrac[31:30];
					mul_a_q     <= {2'b00, tfrac[29:0]};
					mul_b_q     <= PI_Q30;
					mul_start_q <= 1'b1;
					state_q     <= S_THETA;
				end
				S_THETA: begin
					if (mul_done) begin
						theta_q     <= mul_prod[62:31];
						mul_a_q     <= mul_prod[62:31];
						mul_b_q     <= mul_prod[62:31];
						mul_start_q <= 1'b1;
						state_q     <= S_TH2;
					end
				end
				S_TH2: begin
					if (mul_done) begin
						th2_q       <= mul_prod[61:30];
						ssum_q      <= $signed({3'b000, theta_q});
						k_q         <= 3'd1;
						mul_a_q     <= theta_q;
						mul_b_q     <= mul_prod[61:30];
						mul_start_q <= 1'b1;
						state_q     <= S_SMUL;
					end
				end
				S_SMUL: begin
					if (mul_done) begin
						div_n_q     <= mul_prod[61:30];
						div_d_q     <= sin_div(k_q);
						div_start_q <= 1'b1;
						state_q     <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (div_done) begin
						ssum_q      <= k_q[0] ? ssum_q - qv : ssum_q + qv;
						mul_b_q     <= th2_q;
						mul_start_q <= 1'b1;
						if (k_q == 3'd6) begin
							k_q     <= 3'd1;
							csum_q  <= $signed({3'b000, ONE_Q30});
							mul_a_q <= ONE_Q30;
							state_q <= S_CMUL;
						end else begin
							k_q     <= k_q + 3'd1;
							mul_a_q <= div_quo;
							state_q <= S_SMUL;
						end
					end
				end
				S_CMUL: begin
					if (mul_done) begin
						div_n_q     <= mul_prod[61:30];
						div_d_q     <= cos_div(k_q);
						div_start_q <= 1'b1;
						state_q     <= S_CDIV;
					end
				end
				S_CDIV: begin
					if (div_done) begin
						csum_q <= k_q[0] ? csum_q - qv : csum_q + qv;
						if (k_q == 3'd7) begin
							state_q <= S_AXEND;
						end else begin
							k_q         <= k_q + 3'd1;
							mul_a_q     <= div_quo;
							mul_b_q     <= th2_q;
							mul_start_q <= 1'b1;
							state_q     <= S_CMUL;
						end
					end
				end
				S_AXEND: begin
					case (quad_q)
						2'd0: begin
							s_q[ax_q] <= $signed({1'b0, sv});
							c_q[ax_q] <= $signed({1'b0, cv});
						end
						2'd1: begin
							s_q[ax_q] <= $signed({1'b0, cv});
							c_q[ax_q] <= -$signed({1'b0, sv});
						end
						2'd2: begin
							s_q[ax_q] <= -$signed({1'b0, sv});
							c_q[ax_q] <= -$signed({1'b0, cv});
						end
						default: begin
							s_q[ax_q] <= -$signed({1'b0, cv});
							c_q[ax_q] <= $signed({1'b0, sv});
						end
					endcase
					if (ax_q == 2'd2) begin
						pidx_q  <= '0;
						state_q <= S_PSTART;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_ANG;
					end
				end
				S_PSTART: begin
					ent_q[2]    <= -34'(s_q[1]);
					mul_a_q     <= mag32(op_a);
					mul_b_q     <= mag32(op_b);
					neg_q       <= op_a[31] ^ op_b[31];
					mul_start_q <= 1'b1;
					state_q     <= S_PROD;
				end
				S_PROD: begin
					if (mul_done) begin
						case (pidx_q)
							4'd0:  sxsy_q   <= 32'(mres);
							4'd1:  cxsy_q   <= 32'(mres);
							4'd2:  ent_q[0] <= mres;
							4'd3:  ent_q[1] <= mres;
							4'd5:  ent_q[3] <= tmp_q - mres;
							4'd7:  ent_q[4] <= tmp_q + mres;
							4'd8:  ent_q[5] <= mres;
							4'd10: ent_q[6] <= tmp_q + mres;
							4'd12: ent_q[7] <= tmp_q - mres;
							4'd13: ent_q[8] <= mres;
							default: tmp_q  <= mres;
						endcase
						if (pidx_q == 4'd13) begin
							state_q <= S_OUT;
						end else begin
							pidx_q  <= pidx_q + 4'd1;
							state_q <= S_PSTART;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
					end else if (out_ch.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && !out_valid_q) begin
			out_q.matrix_e0    <= to_out(ent_q[0]);
			out_q.matrix_e1    <= to_out(ent_q[1]);
			out_q.matrix_e2    <= to_out(ent_q[2]);
			out_q.matrix_e3    <= to_out(ent_q[3]);
			out_q.matrix_e4    <= to_out(ent_q[4]);
			out_q.matrix_e5    <= to_out(ent_q[5]);
			out_q.matrix_e6    <= to_out(ent_q[6]);
			out_q.matrix_e7    <= to_out(ent_q[7]);
			out_q.matrix_e8    <= to_out(ent_q[8]);
			out_q.elapsed_time <= time_q;
		end
	end
endmodule

[rtl/core/ermg_smul.sv]
// Bit-serial unsigned 32x32 multiplier, one multiplier bit per cycle.
module ermg_smul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [63:0] prod
);
	logic [31:0] mc_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [32:0] sum;

	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : 33'd0);
	assign done = done_q;
	assign prod = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (cnt_q != 6'd0) begin
			hi_q <= sum[32:1];
			lo_q <= {sum[0], lo_q[31:1]};
		end
	end
endmodule

[rtl/core/ermg_sdiv.sv]
// Bit-serial restoring divider, 32-bit dividend by 8-bit divisor.
module ermg_sdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [31:0] quo
);
	logic [31:0] quo_q;
	logic [7:0]  rem_q;
	logic [7:0]  dv_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [8:0]  trial;
	logic        fit;

	assign trial = {rem_q, quo_q[31]};
	assign fit   = trial >= {1'b0, dv_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (cnt_q != 6'd0) begin
			rem_q <= fit ? 8'(trial - {1'b0, dv_q}) : trial[7:0];
			quo_q <= {quo_q[30:0], fit};
		end
	end
endmodule
